@@ hdl/rotate_about_axis_assert.svh @@
// ----------------------------------------------------------------------------
// rotate_about_axis_assert.svh
// Assertion macros used by the checker of the rotation block.
// ----------------------------------------------------------------------------
`ifndef ROTATE_ABOUT_AXIS_ASSERT_SVH
`define ROTATE_ABOUT_AXIS_ASSERT_SVH

// same-cycle implication
`define RAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rab: same-cycle check failed");

// next-cycle implication
`define RAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rab: next-cycle check failed");

`endif

@@ hdl/rab_pkg.sv @@
// ----------------------------------------------------------------------------
// rab_pkg
// Types, constants and tables of the axis rotation block.
// ----------------------------------------------------------------------------
package rab_pkg;

	localparam int SQRT_STEPS   = 32;
	localparam int DIV_STEPS    = 31;
	localparam int CORDIC_STEPS = 28;

	typedef enum logic [1:0] {
		MODE_RAD  = 2'd0,
		MODE_DEG  = 2'd1,
		MODE_GRAD = 2'd2
	} angle_mode_t;

	// phase increment per angle unit, 2^32 per turn
	localparam logic [31:0] K_DEG  = 32'd11930465;
	localparam logic [31:0] K_GRAD = 32'd10737418;
	localparam logic [31:0] K_RAD  = 32'd683565276;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef logic signed [31:0] word_t;
	typedef word_t [2:0] vec3_t;

	typedef struct packed {
		vec3_t vec;
		vec3_t axis;
		word_t angle;
	} item_t;

	typedef struct packed {
		vec3_t vec;
		vec3_t u;
		word_t angle;
		logic  zero;
	} norm_t;

	typedef struct packed {
		vec3_t             vec;
		vec3_t             u;
		logic signed [33:0] c;
		logic signed [33:0] s;
		logic              zero;
	} trig_t;

	typedef struct packed {
		vec3_t pos;
		logic  zero;
	} res_t;

	// arctangent of 2^-i as a fraction of a turn, 2^32 per turn
	function automatic logic [29:0] atan_turn(input int unsigned idx);
		logic [29:0] r;
		unique case (idx)
			0:       r = 30'd536870912;
			1:       r = 30'd316933406;
			2:       r = 30'd167458907;
			3:       r = 30'd85004756;
			4:       r = 30'd42667331;
			5:       r = 30'd21354465;
			6:       r = 30'd10679838;
			7:       r = 30'd5340245;
			8:       r = 30'd2670163;
			9:       r = 30'd1335087;
			10:      r = 30'd667544;
			11:      r = 30'd333772;
			12:      r = 30'd166886;
			13:      r = 30'd83443;
			14:      r = 30'd41722;
			15:      r = 30'd20861;
			16:      r = 30'd10430;
			17:      r = 30'd5215;
			18:      r = 30'd2608;
			19:      r = 30'd1304;
			20:      r = 30'd652;
			21:      r = 30'd326;
			22:      r = 30'd163;
			23:      r = 30'd81;
			24:      r = 30'd41;
			25:      r = 30'd20;
			26:      r = 30'd10;
			27:      r = 30'd5;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/rotate_about_axis.sv @@
// ----------------------------------------------------------------------------
// rotate_about_axis
// Rotates a Q16.16 point about an axis by an angle in radians, degrees or
// grads; zero axis passes the point through and flags it.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata: point, axis, angle
//   m_       out  m_tvalid/m_tready  m_tdata: rotated point, m_tuser: zero axis
//   cfg      in   angle_mode_we      angle_mode_wdata
//
// One request per cycle while the skid register is empty. Path: axis unit
// (square root and divider at one bit per stage), CORDIC (one step per
// stage), combine, output register.
// Reset clears all valid bits and sets the angle unit to degrees.
// A stalled result parks in a skid register; the pipeline freezes only
// while that register is full.
// ----------------------------------------------------------------------------
module rotate_about_axis (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         angle_mode_we,
	input  logic [1:0]   angle_mode_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle
	input  logic [223:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// axis_zero
	output logic [0:0]   m_tuser
);

	logic [1:0] angle_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) angle_mode_q <= rab_pkg::MODE_DEG;
		else if (angle_mode_we) angle_mode_q <= angle_mode_wdata;
	end

	logic           adv;
	rab_pkg::item_t item;

	always_comb begin
		item.vec[0]  = s_tdata[31:0];
		item.vec[1]  = s_tdata[63:32];
		item.vec[2]  = s_tdata[95:64];
		item.axis[0] = s_tdata[127:96];
		item.axis[1] = s_tdata[159:128];
		item.axis[2] = s_tdata[191:160];
		item.angle   = s_tdata[223:192];
	end

	logic           nv;
	rab_pkg::norm_t norm;
	logic           tv;
	rab_pkg::trig_t trig;
	logic           rv;
	rab_pkg::res_t  res;

	rab_axis_unit u_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_tvalid),
		.in_item   (item),
		.out_valid (nv),
		.out_norm  (norm)
	);

	rab_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.angle_mode (angle_mode_q),
		.in_valid   (nv),
		.in_norm    (norm),
		.out_valid  (tv),
		.out_trig   (trig)
	);

	rab_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (tv),
		.in_trig   (trig),
		.out_valid (rv),
		.out_res   (res)
	);

	// output register with skid
	logic          m_valid_q;
	rab_pkg::res_t m_data_q;
	logic          skid_valid_q;
	rab_pkg::res_t skid_data_q;
	logic          push;

	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign push     = adv && rv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (m_tready || !m_valid_q) begin
			m_valid_q    <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !m_valid_q) begin
			m_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (push) begin
			skid_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_data_q.pos[2], m_data_q.pos[1], m_data_q.pos[0]};
	assign m_tuser  = m_data_q.zero;

endmodule

@@ hdl/rab_axis_unit.sv @@
// ----------------------------------------------------------------------------
// rab_axis_unit
// Axis normalization: power-of-two prescale, sum of squares, pipelined
// integer square root, pipelined restoring division to a Q2.30 unit vector.
// ----------------------------------------------------------------------------
module rab_axis_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  rab_pkg::item_t in_item,
	output logic           out_valid,
	output rab_pkg::norm_t out_norm
);

	typedef logic signed [32:0] ax_t;

	typedef struct packed {
		rab_pkg::vec3_t vec;
		rab_pkg::word_t angle;
		logic           zero;
		ax_t [2:0]      a;
	} side_t;

	// ---- prescale
	logic signed [32:0] ext [3];
	logic [32:0]        mag [3];
	logic [32:0]        m_max;
	logic [4:0]         sh;
	side_t              s1_d;

	always_comb begin
		m_max = '0;
		sh    = '0;
		for (int i = 0; i < 3; i++) begin
			ext[i] = {in_item.axis[i][31], in_item.axis[i]};
			mag[i] = ext[i][32] ? 33'(-ext[i]) : 33'(ext[i]);
			if (mag[i] > m_max) m_max = mag[i];
		end
		for (int b = 0; b < 30; b++) begin
			if (m_max[b]) sh = 5'(30 - b);
		end
		if (|m_max[32:30]) sh = '0;
		s1_d.vec   = in_item.vec;
		s1_d.angle = in_item.angle;
		s1_d.zero  = (m_max == '0);
		for (int i = 0; i < 3; i++) begin
			s1_d.a[i] = ext[i] <<< sh;
		end
	end

	logic  v_s1;
	side_t sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) sd_s1 <= s1_d;
	end

	// ---- squares
	logic signed [65:0] sqp [3];
	logic [63:0]        sq_s2 [3];
	logic               v_s2;
	side_t              sd_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqp[i] = $signed(sd_s1.a[i]) * $signed(sd_s1.a[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2 <= sd_s1;
			for (int i = 0; i < 3; i++) sq_s2[i] <= sqp[i][63:0];
		end
	end

	// ---- square root, one result bit per stage
	logic [63:0] l2_sum;
	logic [63:0] rt_n_s  [rab_pkg::SQRT_STEPS+1];
	logic [63:0] rt_r_s  [rab_pkg::SQRT_STEPS+1];
	logic        rt_v_s  [rab_pkg::SQRT_STEPS+1];
	side_t       rt_sd_s [rab_pkg::SQRT_STEPS+1];
	logic [63:0] rt_bit  [rab_pkg::SQRT_STEPS];
	logic [63:0] rt_try  [rab_pkg::SQRT_STEPS];
	logic [63:0] rt_n_d  [rab_pkg::SQRT_STEPS];
	logic [63:0] rt_r_d  [rab_pkg::SQRT_STEPS];

	assign l2_sum = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_comb begin
		for (int k = 0; k < rab_pkg::SQRT_STEPS; k++) begin
			rt_bit[k] = 64'(1) << (62 - 2 * k);
			rt_try[k] = rt_r_s[k] + rt_bit[k];
			if (rt_n_s[k] >= rt_try[k]) begin
				rt_n_d[k] = rt_n_s[k] - rt_try[k];
				rt_r_d[k] = (rt_r_s[k] >> 1) + rt_bit[k];
			end else begin
				rt_n_d[k] = rt_n_s[k];
				rt_r_d[k] = rt_r_s[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= rab_pkg::SQRT_STEPS; k++) rt_v_s[k] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s2;
			for (int k = 0; k < rab_pkg::SQRT_STEPS; k++) rt_v_s[k+1] <= rt_v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_n_s[0]  <= l2_sum;
			rt_r_s[0]  <= '0;
			rt_sd_s[0] <= sd_s2;
			for (int k = 0; k < rab_pkg::SQRT_STEPS; k++) begin
				rt_n_s[k+1]  <= rt_n_d[k];
				rt_r_s[k+1]  <= rt_r_d[k];
				rt_sd_s[k+1] <= rt_sd_s[k];
			end
		end
	end

	// ---- rounded division a * 2^30 / len, one quotient bit per stage
	logic [31:0] len;
	logic [32:0] amag [3];
	logic [61:0] num  [3];

	logic [31:0] dv_rem_s [rab_pkg::DIV_STEPS+1][3];
	logic [30:0] dv_low_s [rab_pkg::DIV_STEPS+1][3];
	logic [30:0] dv_q_s   [rab_pkg::DIV_STEPS+1][3];
	logic [31:0] dv_len_s [rab_pkg::DIV_STEPS+1];
	logic        dv_v_s   [rab_pkg::DIV_STEPS+1];
	side_t       dv_sd_s  [rab_pkg::DIV_STEPS+1];
	logic [32:0] dv_t     [rab_pkg::DIV_STEPS][3];
	logic        dv_ge    [rab_pkg::DIV_STEPS][3];
	logic [31:0] dv_rem_d [rab_pkg::DIV_STEPS][3];

	assign len = rt_r_s[rab_pkg::SQRT_STEPS][31:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag[i] = rt_sd_s[rab_pkg::SQRT_STEPS].a[i][32] ?
				33'(-$signed(rt_sd_s[rab_pkg::SQRT_STEPS].a[i])) :
				33'(rt_sd_s[rab_pkg::SQRT_STEPS].a[i]);
			num[i] = {amag[i][31:0], 30'b0} + 62'(len[31:1]);
		end
		for (int k = 0; k < rab_pkg::DIV_STEPS; k++) begin
			for (int i = 0; i < 3; i++) begin
				dv_t[k][i]  = {dv_rem_s[k][i], dv_low_s[k][i][30]};
				dv_ge[k][i] = dv_t[k][i] >= {1'b0, dv_len_s[k]};
				dv_rem_d[k][i] = dv_ge[k][i] ? 32'(dv_t[k][i] - {1'b0, dv_len_s[k]}) :
					dv_t[k][i][31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= rab_pkg::DIV_STEPS; k++) dv_v_s[k] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= rt_v_s[rab_pkg::SQRT_STEPS];
			for (int k = 0; k < rab_pkg::DIV_STEPS; k++) dv_v_s[k+1] <= dv_v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_len_s[0] <= len;
			dv_sd_s[0]  <= rt_sd_s[rab_pkg::SQRT_STEPS];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= {1'b0, num[i][61:31]};
				dv_low_s[0][i] <= num[i][30:0];
				dv_q_s[0][i]   <= '0;
			end
			for (int k = 0; k < rab_pkg::DIV_STEPS; k++) begin
				dv_len_s[k+1] <= dv_len_s[k];
				dv_sd_s[k+1]  <= dv_sd_s[k];
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[k+1][i] <= dv_rem_d[k][i];
					dv_low_s[k+1][i] <= {dv_low_s[k][i][29:0], 1'b0};
					dv_q_s[k+1][i]   <= {dv_q_s[k][i][29:0], dv_ge[k][i]};
				end
			end
		end
	end

	// ---- sign and output register
	rab_pkg::norm_t norm_d;
	side_t          sd_last;

	always_comb begin
		sd_last      = dv_sd_s[rab_pkg::DIV_STEPS];
		norm_d.vec   = sd_last.vec;
		norm_d.angle = sd_last.angle;
		norm_d.zero  = sd_last.zero;
		for (int i = 0; i < 3; i++) begin
			norm_d.u[i] = sd_last.a[i][32] ?
				32'(-$signed({1'b0, dv_q_s[rab_pkg::DIV_STEPS][i]})) :
				32'({1'b0, dv_q_s[rab_pkg::DIV_STEPS][i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= dv_v_s[rab_pkg::DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) out_norm <= norm_d;
	end

endmodule

@@ hdl/rab_cordic.sv @@
// ----------------------------------------------------------------------------
// rab_cordic
// Angle to phase conversion and a pipelined CORDIC giving cos and sin
// in Q2.30, one rotation step per stage.
// ----------------------------------------------------------------------------
module rab_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [1:0]     angle_mode,
	input  logic           in_valid,
	input  rab_pkg::norm_t in_norm,
	output logic           out_valid,
	output rab_pkg::trig_t out_trig
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// ---- angle times turn constant
	logic [31:0]        kmul;
	logic signed [63:0] prod;

	always_comb begin
		unique case (rab_pkg::angle_mode_t'(angle_mode))
			rab_pkg::MODE_DEG:  kmul = rab_pkg::K_DEG;
			rab_pkg::MODE_GRAD: kmul = rab_pkg::K_GRAD;
			default:            kmul = rab_pkg::K_RAD;
		endcase
		prod = $signed(in_norm.angle) * $signed(kmul);
	end

	logic           v_s1;
	logic [47:0]    prod_s1;
	rab_pkg::norm_t nm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod[47:0];
			nm_s1   <= in_norm;
		end
	end

	// ---- rotation steps
	logic [47:0] ph_sum;

	logic signed [33:0] cx_s [rab_pkg::CORDIC_STEPS+1];
	logic signed [33:0] cy_s [rab_pkg::CORDIC_STEPS+1];
	logic signed [31:0] cz_s [rab_pkg::CORDIC_STEPS+1];
	logic [1:0]         cq_s [rab_pkg::CORDIC_STEPS+1];
	logic               cv_s [rab_pkg::CORDIC_STEPS+1];
	rab_pkg::norm_t     cn_s [rab_pkg::CORDIC_STEPS+1];

	logic signed [33:0] cx_d [rab_pkg::CORDIC_STEPS];
	logic signed [33:0] cy_d [rab_pkg::CORDIC_STEPS];
	logic signed [31:0] cz_d [rab_pkg::CORDIC_STEPS];
	logic signed [31:0] at   [rab_pkg::CORDIC_STEPS];

	assign ph_sum = prod_s1 + 48'd32768;

	always_comb begin
		for (int k = 0; k < rab_pkg::CORDIC_STEPS; k++) begin
			at[k] = $signed({2'b00, rab_pkg::atan_turn(k)});
			if (!cz_s[k][31]) begin
				cx_d[k] = cx_s[k] - (cy_s[k] >>> k);
				cy_d[k] = cy_s[k] + (cx_s[k] >>> k);
				cz_d[k] = cz_s[k] - at[k];
			end else begin
				cx_d[k] = cx_s[k] + (cy_s[k] >>> k);
				cy_d[k] = cy_s[k] - (cx_s[k] >>> k);
				cz_d[k] = cz_s[k] + at[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= rab_pkg::CORDIC_STEPS; k++) cv_s[k] <= 1'b0;
		end else if (en) begin
			cv_s[0] <= v_s1;
			for (int k = 0; k < rab_pkg::CORDIC_STEPS; k++) cv_s[k+1] <= cv_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= rab_pkg::CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= $signed({2'b00, ph_sum[45:16]});
			cq_s[0] <= ph_sum[47:46];
			cn_s[0] <= nm_s1;
			for (int k = 0; k < rab_pkg::CORDIC_STEPS; k++) begin
				cx_s[k+1] <= cx_d[k];
				cy_s[k+1] <= cy_d[k];
				cz_s[k+1] <= cz_d[k];
				cq_s[k+1] <= cq_s[k];
				cn_s[k+1] <= cn_s[k];
			end
		end
	end

	// ---- quadrant fold and output register
	rab_pkg::trig_t     trig_d;
	logic signed [33:0] fx;
	logic signed [33:0] fy;

	always_comb begin
		fx          = cx_s[rab_pkg::CORDIC_STEPS];
		fy          = cy_s[rab_pkg::CORDIC_STEPS];
		trig_d.vec  = cn_s[rab_pkg::CORDIC_STEPS].vec;
		trig_d.u    = cn_s[rab_pkg::CORDIC_STEPS].u;
		trig_d.zero = cn_s[rab_pkg::CORDIC_STEPS].zero;
		unique case (cq_s[rab_pkg::CORDIC_STEPS])
			QUAD_0: begin trig_d.c = fx;  trig_d.s = fy;  end
			QUAD_1: begin trig_d.c = -fy; trig_d.s = fx;  end
			QUAD_2: begin trig_d.c = -fx; trig_d.s = -fy; end
			QUAD_3: begin trig_d.c = fy;  trig_d.s = -fx; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= cv_s[rab_pkg::CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) out_trig <= trig_d;
	end

endmodule

@@ hdl/rab_combine.sv @@
// ----------------------------------------------------------------------------
// rab_combine
// Splits the point along and across the unit axis, rotates the cross part
// with cos and sin, adds back, saturates to Q16.16; zero axis passes through.
// ----------------------------------------------------------------------------
module rab_combine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  rab_pkg::trig_t in_trig,
	output logic           out_valid,
	output rab_pkg::res_t  out_res
);

	localparam logic signed [63:0] RND64 = 64'sd536870912;
	localparam logic signed [65:0] RND66 = 66'sd536870912;
	localparam logic signed [69:0] RND70 = 70'sd536870912;
	localparam logic signed [67:0] RND68 = 68'sd536870912;
	localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
	localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

	// ---- s1: dot and cross products
	logic signed [63:0] pd [3];
	logic signed [63:0] pc [6];
	logic signed [63:0] pd_s1 [3];
	logic signed [63:0] pc_s1 [6];
	logic               v_s1;
	rab_pkg::trig_t     tr_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pd[i] = $signed(in_trig.u[i]) * $signed(in_trig.vec[i]);
		end
		pc[0] = $signed(in_trig.u[1]) * $signed(in_trig.vec[2]);
		pc[1] = $signed(in_trig.u[2]) * $signed(in_trig.vec[1]);
		pc[2] = $signed(in_trig.u[2]) * $signed(in_trig.vec[0]);
		pc[3] = $signed(in_trig.u[0]) * $signed(in_trig.vec[2]);
		pc[4] = $signed(in_trig.u[0]) * $signed(in_trig.vec[1]);
		pc[5] = $signed(in_trig.u[1]) * $signed(in_trig.vec[0]);
	end

	// ---- s2: rounded dot and cross vector
	logic signed [63:0] dot;
	logic signed [63:0] dif [3];
	logic signed [33:0] d_s2;
	logic signed [33:0] w_s2 [3];
	logic               v_s2;
	rab_pkg::trig_t     tr_s2;

	always_comb begin
		dot = pd_s1[0] + pd_s1[1] + pd_s1[2];
		for (int i = 0; i < 3; i++) begin
			dif[i] = pc_s1[2*i] - pc_s1[2*i+1];
		end
	end

	// ---- s3: u * d
	logic signed [65:0] ud [3];
	logic signed [65:0] ud_s3 [3];
	logic signed [33:0] w_s3 [3];
	logic               v_s3;
	rab_pkg::trig_t     tr_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ud[i] = $signed(tr_s2.u[i]) * d_s2;
		end
	end

	// ---- s4: along and cross parts
	logic signed [34:0] alg [3];
	logic signed [35:0] crs [3];
	logic signed [34:0] alg_s4 [3];
	logic signed [35:0] crs_s4 [3];
	logic signed [33:0] w_s4 [3];
	logic               v_s4;
	rab_pkg::trig_t     tr_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			alg[i] = 35'((ud_s3[i] + RND66) >>> 30);
			crs[i] = $signed(tr_s3.vec[i]) - alg[i];
		end
	end

	// ---- s5: rotation products
	logic signed [69:0] cc [3];
	logic signed [67:0] ws [3];
	logic signed [69:0] cc_s5 [3];
	logic signed [67:0] ws_s5 [3];
	logic signed [34:0] alg_s5 [3];
	logic               v_s5;
	rab_pkg::trig_t     tr_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cc[i] = crs_s4[i] * tr_s4.c;
			ws[i] = w_s4[i] * tr_s4.s;
		end
	end

	// ---- s6: sum and saturate
	logic signed [41:0] tot [3];
	rab_pkg::res_t      res_d;

	always_comb begin
		res_d.zero = tr_s5.zero;
		for (int i = 0; i < 3; i++) begin
			tot[i] = alg_s5[i] + 42'((cc_s5[i] + RND70) >>> 30) +
				42'((ws_s5[i] + RND68) >>> 30);
			if (tr_s5.zero) res_d.pos[i] = tr_s5.vec[i];
			else if (tot[i] > SAT_HI) res_d.pos[i] = 32'h7fff_ffff;
			else if (tot[i] < SAT_LO) res_d.pos[i] = 32'h8000_0000;
			else res_d.pos[i] = tot[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tr_s1 <= in_trig;
			tr_s2 <= tr_s1;
			tr_s3 <= tr_s2;
			tr_s4 <= tr_s3;
			tr_s5 <= tr_s4;
			d_s2  <= 34'((dot + RND64) >>> 30);
			for (int i = 0; i < 3; i++) begin
				pd_s1[i]  <= pd[i];
				w_s2[i]   <= 34'((dif[i] + RND64) >>> 30);
				ud_s3[i]  <= ud[i];
				w_s3[i]   <= w_s2[i];
				alg_s4[i] <= alg[i];
				crs_s4[i] <= crs[i];
				w_s4[i]   <= w_s3[i];
				cc_s5[i]  <= cc[i];
				ws_s5[i]  <= ws[i];
				alg_s5[i] <= alg_s4[i];
			end
			for (int j = 0; j < 6; j++) pc_s1[j] <= pc[j];
			out_res <= res_d;
		end
	end

endmodule

@@ hdl/rab_checker.sv @@
// ----------------------------------------------------------------------------
// rab_checker
// Port-level checks of the rotation block, bound to its top level.
// ----------------------------------------------------------------------------
`include "rotate_about_axis_assert.svh"

module rab_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         angle_mode_we,
	input logic [1:0]   angle_mode_wdata,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [223:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [0:0]   m_tuser
);

	`RAB_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`RAB_ASSERT_IMP(a_stall_full, clk, arst_n, !s_tready, m_tvalid)
	`RAB_ASSERT_IMP(a_ready_fall, clk, arst_n, $fell(s_tready), $past(m_tvalid && !m_tready))
	`RAB_ASSERT_IMP(a_ready_rise, clk, arst_n, $rose(s_tready), $past(m_tready))

endmodule

bind rotate_about_axis rab_checker u_rab_checker (.*);

@@ verif/tb_rotate_about_axis.sv @@
// ----------------------------------------------------------------------------
// tb_rotate_about_axis
// Self-checking bench for the axis rotation block. A scoreboard object
// predicts each rotated point from the accepted request and the current angle
// unit. Results are compared field by field in order. Phases cover each angle
// unit, directed edge cases, random traffic under sender and receiver idling,
// and a long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_rotate_about_axis;

	localparam int LIMIT = 400000;

	// unit code outside the defined set, read as radians
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               zero;
	} point_t;

	class rotation_board;
		point_t          pending[$];
		logic [1:0]      unit_sel = rab_pkg::MODE_DEG;
		int              errors = 0;
		longint          atan_q[28] = '{
			536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

		function longint rnd30(longint v);
			return (v + 64'sd536870912) >>> 30;
		endfunction

		function longint root(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return longint'(r);
		endfunction

		function longint divr(longint n, longint d);
			return n >= 0 ? (n + d / 2) / d : -(((-n) + d / 2) / d);
		endfunction

		function longint clip(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function point_t rotated(logic [223:0] d);
			point_t r;
			longint v[3], a[3], u[3], w[3], m, t, len, cs, sn, x, y, z, dx, dy, dt, al, cr;
			longint unsigned l2, p, k;
			logic [31:0] ph;
			int sh;
			for (int i = 0; i < 3; i++) begin
				v[i] = $signed(d[32*i +: 32]);
				a[i] = $signed(d[32*(i+3) +: 32]);
			end
			if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
				r.x = v[0]; r.y = v[1]; r.z = v[2]; r.zero = 1'b1;
				return r;
			end
			m = 0;
			for (int i = 0; i < 3; i++) begin
				t = a[i] < 0 ? -a[i] : a[i];
				if (t > m) m = t;
			end
			sh = 0;
			while ((m << sh) < 64'sd1073741824) sh++;
			l2 = 0;
			for (int i = 0; i < 3; i++) begin
				a[i] = a[i] << sh;
				l2 = l2 + longint'(a[i] * a[i]);
			end
			len = root(l2);
			for (int i = 0; i < 3; i++) u[i] = divr(a[i] * 64'sd1073741824, len);
			case (unit_sel)
				rab_pkg::MODE_DEG:  k = rab_pkg::K_DEG;
				rab_pkg::MODE_GRAD: k = rab_pkg::K_GRAD;
				default:            k = rab_pkg::K_RAD;
			endcase
			t = $signed(d[223:192]);
			p = longint'(t) * k + 64'd32768;
			ph = p[47:16];
			x = rab_pkg::CORDIC_GAIN;
			y = 0;
			z = ph[29:0];
			for (int i = 0; i < 28; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - atan_q[i];
				end else begin
					x = x + dx; y = y - dy; z = z + atan_q[i];
				end
			end
			case (ph[31:30])
				2'd0: begin cs = x;  sn = y;  end
				2'd1: begin cs = -y; sn = x;  end
				2'd2: begin cs = -x; sn = -y; end
				default: begin cs = y; sn = -x; end
			endcase
			dt = rnd30(u[0] * v[0] + u[1] * v[1] + u[2] * v[2]);
			w[0] = rnd30(u[1] * v[2] - u[2] * v[1]);
			w[1] = rnd30(u[2] * v[0] - u[0] * v[2]);
			w[2] = rnd30(u[0] * v[1] - u[1] * v[0]);
			for (int i = 0; i < 3; i++) begin
				al = rnd30(u[i] * dt);
				cr = v[i] - al;
				v[i] = clip(al + rnd30(cr * cs) + rnd30(w[i] * sn));
			end
			r.x = v[0]; r.y = v[1]; r.z = v[2]; r.zero = 1'b0;
			return r;
		endfunction

		function void note_request(logic [223:0] d);
			pending.push_back(rotated(d));
		endfunction

		function void check_result(logic [95:0] d, logic zf);
			point_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[31:0] !== e.x) begin
				$error("out_x expected %0d actual %0d", e.x, $signed(d[31:0])); errors++;
			end
			if (d[63:32] !== e.y) begin
				$error("out_y expected %0d actual %0d", e.y, $signed(d[63:32])); errors++;
			end
			if (d[95:64] !== e.z) begin
				$error("out_z expected %0d actual %0d", e.z, $signed(d[95:64])); errors++;
			end
			if (zf !== e.zero) begin
				$error("axis_zero expected %0d actual %0d", e.zero, zf); errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         angle_mode_we = 0;
	logic [1:0]   angle_mode_wdata = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;

	rotation_board board = new();
	int send_idle = 0;
	int recv_stall = 0;
	int hold_req = 0;
	int hold_left = 0;
	int cycles = 0;

	rotate_about_axis dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_request(logic [223:0] d);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_request(d);
	endtask

	task automatic set_unit(logic [1:0] val);
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		angle_mode_we <= 1'b1;
		angle_mode_wdata <= val;
		@(posedge clk);
		angle_mode_we <= 1'b0;
		board.unit_sel = val;
	endtask

	function automatic logic [223:0] pack_req(longint vx, longint vy, longint vz,
			longint ax, longint ay, longint az, longint ang);
		return {ang[31:0], az[31:0], ay[31:0], ax[31:0], vz[31:0], vy[31:0], vx[31:0]};
	endfunction

	function automatic logic [31:0] rnd_word();
		logic [31:0] r;
		r = $urandom;
		if ($urandom_range(2) != 0) r = $signed(r) >>> $urandom_range(31);
		return r;
	endfunction

	function automatic logic [223:0] rnd_req();
		logic [223:0] r;
		for (int i = 0; i < 7; i++) r[32*i +: 32] = rnd_word();
		if ($urandom_range(9) == 0) r[191:96] = '0;
		else if ($urandom_range(9) == 0) r[32*(3 + $urandom_range(2)) +: 32] = '0;
		return r;
	endfunction

	task automatic random_run(int n, int idle, int stall);
		send_idle = idle;
		recv_stall = stall;
		repeat (n) send_request(rnd_req());
	endtask

	localparam longint ONE = 65536;
	localparam longint MAXW = 64'sd2147483647;
	localparam longint MINW = -64'sd2147483648;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset unit is degrees
		send_request(pack_req(ONE, 0, 0, 0, 0, ONE, 90 * ONE));
		send_request(pack_req(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 45 * ONE));
		send_request(pack_req(MAXW, MINW, MAXW, 0, 0, 0, 0));
		send_request(pack_req(MAXW, MAXW, MAXW, 0, 0, ONE, 45 * ONE));
		send_request(pack_req(MINW, MINW, MINW, MINW, MINW, MINW, 180 * ONE));
		send_request(pack_req(MAXW, MINW, 0, MAXW, MAXW, MAXW, -120 * ONE));
		send_request(pack_req(ONE, ONE, ONE, 1, 0, 0, 30 * ONE));
		send_request(pack_req(-ONE, 5, -7, 0, -1, 1, MAXW));
		send_request(pack_req(12345, -54321, 999, 3, 4, 0, MINW));
		send_request(pack_req(ONE, 0, 0, ONE, ONE, 0, 0));
		send_request(pack_req(MAXW, 0, 0, 0, MAXW, 0, 270 * ONE));
		set_unit(rab_pkg::MODE_RAD);
		send_request(pack_req(ONE, 0, 0, 0, 0, ONE, 102944));
		send_request(pack_req(0, ONE, 0, ONE, 0, 0, -205887));
		send_request(pack_req(MAXW, MAXW, MINW, -ONE, 2 * ONE, 0, MAXW));
		set_unit(rab_pkg::MODE_GRAD);
		send_request(pack_req(ONE, 0, 0, 0, 0, ONE, 100 * ONE));
		send_request(pack_req(ONE, ONE, 0, 0, 1, 0, -50 * ONE));
		send_request(pack_req(MINW, MAXW, MINW, MAXW, 0, MINW, MINW));
		set_unit(MODE_SPARE);
		send_request(pack_req(ONE, 0, 0, 0, 0, ONE, 102944));
		send_request(pack_req(MAXW, MAXW, MAXW, 1, 1, 1, MAXW));

		random_run(140, 0, 0);
		set_unit(rab_pkg::MODE_RAD);
		random_run(140, 83, 0);
		set_unit(rab_pkg::MODE_GRAD);
		random_run(140, 0, 83);
		set_unit(rab_pkg::MODE_DEG);
		random_run(140, 26, 26);

		// long receiver hold-off while the sender keeps pushing
		hold_req = 400;
		random_run(150, 0, 0);
		s_tvalid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
